### hw/rtl/evr_pkg.sv
//------------------------------------------------------------------------------
// evr_pkg
// Shared types, constants and the trig sequencer program for the Euler
// vertex rotation block.
//------------------------------------------------------------------------------
package evr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int TRIG_WIDTH  = 18;
  localparam int TRIG_FRAC   = TRIG_WIDTH - 2;
  localparam int ANG_WIDTH   = 18;
  localparam int IDX_WIDTH   = 2;
  localparam int TDATA_W     = ((3 * COORD_WIDTH + 7) / 8) * 8;

  // Register indexes of the configuration port.
  localparam logic [IDX_WIDTH-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_ANGLE_Z = 2'd2;
  localparam logic [IDX_WIDTH-1:0] REG_ORDER   = 2'd3;

  // Angle reduction, in 1/256 degree units.
  localparam int FULL_TURN    = 92160;
  localparam int QUARTER_TURN = 23040;
  localparam int EIGHTH_TURN  = 11520;
  localparam int RED_W        = ANG_WIDTH + 1;
  localparam int G_W          = $clog2(EIGHTH_TURN + 1);

  // Q1.30 series arithmetic.
  localparam int Q_FRAC     = 30;
  localparam int QW         = Q_FRAC + 1;
  localparam int PI_W       = 32;
  localparam int MUL_W      = QW + PI_W;
  localparam int DIVD_W     = 30;
  localparam int DIVS_W     = 16;
  localparam int STEP_W     = 5;
  localparam int TRIG_SHIFT = Q_FRAC - TRIG_FRAC;

  // Division by a constant: multiply by floor(2^RCP_SHIFT / d), then correct
  // the estimate once by the remainder. Exact for dividends below 2^30.
  localparam int     RCP_SHIFT = 30;
  localparam int     RCP_W     = 30;
  localparam longint RCP_ONE   = longint'(1) << RCP_SHIFT;

  localparam logic [PI_W-1:0] PI_Q30  = 32'd3373259426;
  localparam logic [QW-1:0]   ONE_Q   = {1'b1, {Q_FRAC{1'b0}}};
  localparam logic [QW-1:0]   TRIG_RND = QW'(1) << (TRIG_SHIFT - 1);
  localparam int              DEG_DIV = 46080;
  localparam int              DEG_RND = DEG_DIV / 2;

  // pi split as PI_HI * 46080 + PI_LO, so only the small part is divided.
  localparam int PI_HI = int'(PI_Q30 / DEG_DIV);
  localparam int PI_LO = int'(PI_Q30 % DEG_DIV);

  // Rotation datapath widths.
  localparam int PROD_W = COORD_WIDTH + TRIG_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHR_W  = SUM_W - TRIG_FRAC;
  localparam logic signed [SUM_W-1:0] ROT_RND = SUM_W'(1) << (TRIG_FRAC - 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [TRIG_WIDTH-1:0]  trig_val_t;

  localparam trig_val_t TRIG_ONE = {2'b01, {TRIG_FRAC{1'b0}}};

  // x sits in the lowest bits when packed.
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec_t;

  typedef struct packed {
    trig_val_t s;
    trig_val_t c;
  } trig_pair_t;

  typedef enum logic [1:0] {
    PL_XY,
    PL_XZ,
    PL_YZ
  } plane_t;

  typedef enum logic [3:0] {
    OP_REDUCE,
    OP_MULG,
    OP_MULXX,
    OP_MULX2T,
    OP_MULXT,
    OP_LDX2,
    OP_DIV_X,
    OP_DIV_T,
    OP_DIV_C,
    OP_FIN
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t            kind;
    logic [DIVS_W-1:0]    divisor;
    logic [RCP_W-1:0]     recip;
  } uop_t;

  // Program for one angle: reduce, convert to radians, then Horner
  // evaluation of the sine and cosine series.
  function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
    uop_t u;
    u.divisor = DIVS_W'(1);
    u.recip   = '0;
    case (step)
      5'd0:    u.kind = OP_REDUCE;
      5'd1:    u.kind = OP_MULG;
      5'd2:    begin
        u.kind = OP_DIV_X; u.divisor = DIVS_W'(DEG_DIV); u.recip = RCP_W'(RCP_ONE / DEG_DIV);
      end
      5'd3:    u.kind = OP_MULXX;
      5'd4:    begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(72); u.recip = RCP_W'(RCP_ONE / 72);
      end
      5'd5:    u.kind = OP_MULX2T;
      5'd6:    begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(42); u.recip = RCP_W'(RCP_ONE / 42);
      end
      5'd7:    u.kind = OP_MULX2T;
      5'd8:    begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(20); u.recip = RCP_W'(RCP_ONE / 20);
      end
      5'd9:    u.kind = OP_MULX2T;
      5'd10:   begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(6); u.recip = RCP_W'(RCP_ONE / 6);
      end
      5'd11:   u.kind = OP_MULXT;
      5'd12:   u.kind = OP_LDX2;
      5'd13:   begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(90); u.recip = RCP_W'(RCP_ONE / 90);
      end
      5'd14:   u.kind = OP_MULX2T;
      5'd15:   begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(56); u.recip = RCP_W'(RCP_ONE / 56);
      end
      5'd16:   u.kind = OP_MULX2T;
      5'd17:   begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(30); u.recip = RCP_W'(RCP_ONE / 30);
      end
      5'd18:   u.kind = OP_MULX2T;
      5'd19:   begin
        u.kind = OP_DIV_T; u.divisor = DIVS_W'(12); u.recip = RCP_W'(RCP_ONE / 12);
      end
      5'd20:   u.kind = OP_MULX2T;
      5'd21:   begin
        u.kind = OP_DIV_C; u.divisor = DIVS_W'(2); u.recip = RCP_W'(RCP_ONE / 2);
      end
      default: u.kind = OP_FIN;
    endcase
    return u;
  endfunction

  function automatic coord_t sat_coord(input logic signed [SHR_W-1:0] v);
    logic signed [SHR_W-1:0] hi;
    logic signed [SHR_W-1:0] lo;
    hi = {{(SHR_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    lo = {{(SHR_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
    if (v > hi) begin
      return hi[COORD_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[COORD_WIDTH-1:0];
    end
    return v[COORD_WIDTH-1:0];
  endfunction

endpackage

### hw/rtl/evr_div.sv
//------------------------------------------------------------------------------
// evr_div
// Unsigned division by a small constant divisor: a reciprocal multiply gives
// an estimate that is at most one low, and one remainder check corrects it.
// The estimate is registered at start; the remainder check then registers the quotient and raises done.
//------------------------------------------------------------------------------
module evr_div import evr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  input  logic [RCP_W-1:0]  recip,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int EST_W  = DIVD_W + RCP_W;
  localparam int BACK_W = DIVD_W + DIVS_W;

  logic              pend;
  logic [DIVD_W-1:0] num;
  logic [DIVS_W-1:0] dsr;
  logic [DIVD_W-1:0] q_est;
  logic [DIVD_W-1:0] quo;
  logic [EST_W-1:0]  est_prod;
  logic [BACK_W-1:0] back_prod;
  logic [DIVD_W-1:0] rem;

  always_comb begin
    est_prod  = EST_W'(dividend) * EST_W'(recip);
    back_prod = BACK_W'(q_est) * BACK_W'(dsr);
    rem       = num - back_prod[DIVD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        pend  <= 1'b1;
        num   <= dividend;
        dsr   <= divisor;
        q_est <= est_prod[EST_W-1:RCP_SHIFT];
      end else if (pend) begin
        pend <= 1'b0;
        done <= 1'b1;
        quo  <= (rem >= DIVD_W'(dsr)) ? q_est + DIVD_W'(1) : q_est;
      end
    end
  end

  assign quotient = quo;

endmodule

### hw/rtl/evr_trig_seq.sv
//------------------------------------------------------------------------------
// evr_trig_seq
// Sequencer that recomputes the sine and cosine of one angle and holds the
// three cached pairs.
//------------------------------------------------------------------------------
module evr_trig_seq import evr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [IDX_WIDTH-1:0] sel,
  input  logic [ANG_WIDTH-1:0] angle,
  output logic                 busy,
  output trig_pair_t           trig_x,
  output trig_pair_t           trig_y,
  output trig_pair_t           trig_z
);

  logic [STEP_W-1:0]    step;
  logic                 div_wait;
  logic [IDX_WIDTH-1:0] sel_r;
  logic [ANG_WIDTH-1:0] ang_r;
  logic [1:0]           quad;
  logic                 swp;
  logic [G_W-1:0]       g;
  logic [QW-1:0]        x;
  logic [QW-1:0]        x2;
  logic [QW-1:0]        t;
  logic [QW-1:0]        sv;
  logic [QW-1:0]        cv;
  logic [DIVD_W-1:0]    acc;
  trig_val_t            sin_c [3];
  trig_val_t            cos_c [3];

  uop_t                 uop;
  logic signed [RED_W-1:0] a_ext;
  logic signed [RED_W-1:0] full_r;
  logic [RED_W-1:0]     r_u;
  logic [RED_W-1:0]     f;
  logic [1:0]           quad_next;
  logic [G_W-1:0]       g_next;
  logic [QW-1:0]        mul_a;
  logic [PI_W-1:0]      mul_b;
  logic [MUL_W-1:0]     prod;
  logic [QW-1:0]        prod_q;
  logic                 is_div;
  logic                 div_start;
  logic                 div_done;
  logic [DIVD_W-1:0]    div_quo;
  logic [QW-1:0]        div_q;
  logic [QW-1:0]        sr_full;
  logic [QW-1:0]        cr_full;
  trig_val_t            sf;
  trig_val_t            cf;
  trig_val_t            s_out;
  trig_val_t            c_out;

  assign uop = uop_at(step);

  // Angle reduction into [0, full turn), then quadrant and octant fold.
  always_comb begin
    full_r = RED_W'(FULL_TURN);
    a_ext  = {ang_r[ANG_WIDTH-1], ang_r};
    if (a_ext < -full_r) begin
      r_u = a_ext + full_r + full_r;
    end else if (a_ext < 0) begin
      r_u = a_ext + full_r;
    end else if (a_ext >= full_r) begin
      r_u = a_ext - full_r;
    end else begin
      r_u = a_ext;
    end
    if (r_u >= RED_W'(3 * QUARTER_TURN)) begin
      quad_next = 2'd3;
      f         = r_u - RED_W'(3 * QUARTER_TURN);
    end else if (r_u >= RED_W'(2 * QUARTER_TURN)) begin
      quad_next = 2'd2;
      f         = r_u - RED_W'(2 * QUARTER_TURN);
    end else if (r_u >= RED_W'(QUARTER_TURN)) begin
      quad_next = 2'd1;
      f         = r_u - RED_W'(QUARTER_TURN);
    end else begin
      quad_next = 2'd0;
      f         = r_u;
    end
    if (f <= RED_W'(EIGHTH_TURN)) begin
      g_next = f[G_W-1:0];
    end else begin
      g_next = G_W'(RED_W'(QUARTER_TURN) - f);
    end
  end

  // One shared multiplier for the product steps; OP_MULG also forms g * PI_HI apart.
  always_comb begin
    case (uop.kind)
      OP_MULG:   begin mul_a = QW'(g); mul_b = PI_W'(PI_LO); end
      OP_MULXX:  begin mul_a = x;      mul_b = PI_W'(x);  end
      OP_MULXT:  begin mul_a = x;      mul_b = PI_W'(t);  end
      default:   begin mul_a = x2;     mul_b = PI_W'(t);  end
    endcase
    prod   = MUL_W'(mul_a) * MUL_W'(mul_b);
    prod_q = prod[Q_FRAC+QW-1:Q_FRAC];
  end

  assign is_div    = (uop.kind == OP_DIV_X) || (uop.kind == OP_DIV_T) ||
                     (uop.kind == OP_DIV_C);
  assign div_start = busy && is_div && !div_wait;
  assign div_q     = QW'(div_quo);

  evr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (uop.divisor),
    .recip    (uop.recip),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Round to the cache format, fold the octant back, then apply the quadrant.
  always_comb begin
    sr_full = sv + TRIG_RND;
    cr_full = cv + TRIG_RND;
    sf      = TRIG_WIDTH'(sr_full >> TRIG_SHIFT);
    cf      = TRIG_WIDTH'(cr_full >> TRIG_SHIFT);
    if (swp) begin
      sf = TRIG_WIDTH'(cr_full >> TRIG_SHIFT);
      cf = TRIG_WIDTH'(sr_full >> TRIG_SHIFT);
    end
    case (quad)
      2'd0:    begin s_out = sf;  c_out = cf;  end
      2'd1:    begin s_out = cf;  c_out = -sf; end
      2'd2:    begin s_out = -sf; c_out = -cf; end
      default: begin s_out = -cf; c_out = sf;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      div_wait <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sin_c[i] <= '0;
        cos_c[i] <= TRIG_ONE;
      end
    end else if (!busy) begin
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        sel_r <= sel;
        ang_r <= angle;
      end
    end else begin
      case (uop.kind)
        OP_REDUCE: begin
          g    <= g_next;
          quad <= quad_next;
          swp  <= f > RED_W'(EIGHTH_TURN);
          step <= step + STEP_W'(1);
        end
        OP_MULG: begin
          // The g * PI_HI part of g * pi / 46080 needs no division.
          x    <= QW'(g) * QW'(PI_HI);
          acc  <= prod[DIVD_W-1:0] + DIVD_W'(DEG_RND);
          step <= step + STEP_W'(1);
        end
        OP_MULXX: begin
          x2   <= prod_q;
          acc  <= DIVD_W'(prod_q);
          step <= step + STEP_W'(1);
        end
        OP_MULX2T: begin
          acc  <= DIVD_W'(prod_q);
          step <= step + STEP_W'(1);
        end
        OP_MULXT: begin
          sv   <= prod_q;
          step <= step + STEP_W'(1);
        end
        OP_LDX2: begin
          acc  <= DIVD_W'(x2);
          step <= step + STEP_W'(1);
        end
        OP_DIV_X, OP_DIV_T, OP_DIV_C: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
          end else if (div_done) begin
            div_wait <= 1'b0;
            step     <= step + STEP_W'(1);
            if (uop.kind == OP_DIV_X) begin
              x <= x + div_q;
            end else if (uop.kind == OP_DIV_T) begin
              t <= ONE_Q - div_q;
            end else begin
              cv <= ONE_Q - div_q;
            end
          end
        end
        OP_FIN: begin
          for (int i = 0; i < 3; i++) begin
            if (sel_r == IDX_WIDTH'(i)) begin
              sin_c[i] <= s_out;
              cos_c[i] <= c_out;
            end
          end
          busy <= 1'b0;
          step <= '0;
        end
        default: begin
          busy <= 1'b0;
          step <= '0;
        end
      endcase
    end
  end

  assign trig_x = '{s: sin_c[0], c: cos_c[0]};
  assign trig_y = '{s: sin_c[1], c: cos_c[1]};
  assign trig_z = '{s: sin_c[2], c: cos_c[2]};

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("refresh did not start");
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == '0) else $error("program counter not parked while idle");
  a_div_in_refresh: assert property (@(posedge clk) disable iff (rst)
    div_wait |-> busy) else $error("divider wait outside a refresh");

endmodule

### hw/rtl/evr_rot_stage.sv
//------------------------------------------------------------------------------
// evr_rot_stage
// One planar rotation: a multiply level and a round-and-saturate level.
//------------------------------------------------------------------------------
module evr_rot_stage import evr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  plane_t     plane,
  input  trig_pair_t trig,
  input  logic       in_valid,
  output logic       in_ready,
  input  vec_t       in_vec,
  output logic       out_valid,
  input  logic       out_ready,
  output vec_t       out_vec
);

  typedef logic signed [PROD_W-1:0] prod_t;

  coord_t u;
  coord_t v;
  prod_t  p_uc;
  prod_t  p_vs;
  prod_t  p_us;
  prod_t  p_vc;
  vec_t   vec1;
  plane_t plane1;
  logic   valid1;
  logic   ready1;
  logic   ready2;
  logic signed [SUM_W-1:0] sum_u;
  logic signed [SUM_W-1:0] sum_v;
  coord_t nu;
  coord_t nv;
  vec_t   vec_next;

  always_comb begin
    case (plane)
      PL_XZ:   begin u = in_vec.x; v = in_vec.z; end
      PL_YZ:   begin u = in_vec.y; v = in_vec.z; end
      default: begin u = in_vec.x; v = in_vec.y; end
    endcase
  end

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !valid1 || ready2;
  assign in_ready = ready1;

  always_comb begin
    sum_u = SUM_W'(p_uc) - SUM_W'(p_vs) + ROT_RND;
    sum_v = SUM_W'(p_us) + SUM_W'(p_vc) + ROT_RND;
    nu    = sat_coord(sum_u[SUM_W-1:TRIG_FRAC]);
    nv    = sat_coord(sum_v[SUM_W-1:TRIG_FRAC]);
    vec_next = vec1;
    case (plane1)
      PL_XZ:   begin vec_next.x = nu; vec_next.z = nv; end
      PL_YZ:   begin vec_next.y = nu; vec_next.z = nv; end
      default: begin vec_next.x = nu; vec_next.y = nv; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        valid1 <= in_valid;
        if (in_valid) begin
          p_uc   <= u * trig.c;
          p_vs   <= v * trig.s;
          p_us   <= u * trig.s;
          p_vc   <= v * trig.c;
          vec1   <= in_vec;
          plane1 <= plane;
        end
      end
      if (ready2) begin
        out_valid <= valid1;
        if (valid1) begin
          out_vec <= vec_next;
        end
      end
    end
  end

endmodule

### hw/rtl/euler_vertex_rotation_top.sv
//------------------------------------------------------------------------------
// euler_vertex_rotation_top
// Rotates a Q16.16 vertex by three configured Euler angles.
//
//   Channel  Handshake          Payload
//   s_*      tvalid / tready    tdata: in_x, in_y, in_z
//   m_*      tvalid / tready    tdata: out_x, out_y, out_z
//   cfg_*    valid / ready      index 0..3, data (angle or order in bit 0)
//
// One vertex per cycle while no stall or refresh holds the input (three rotations,
// each a multiply level and a round-and-saturate level).
// A write to an angle register starts a refresh of that angle's sine and
// cosine: thirteen steps plus ten constant divisions in the trig sequencer.
// s_tready and cfg_ready are low during the refresh.
// After reset all angles are zero and the cache holds sine 0, cosine 1.
// A stall at m_tready holds every full stage; nothing is dropped or repeated.
//------------------------------------------------------------------------------
module euler_vertex_rotation_top import evr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,   // in_x, in_y, in_z
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // out_x, out_y, out_z
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [ANG_WIDTH-1:0] cfg_data
);

  logic       order;
  logic       busy;
  logic       cfg_fire;
  trig_pair_t trig_x;
  trig_pair_t trig_y;
  trig_pair_t trig_z;
  plane_t     plane1;
  plane_t     plane2;
  trig_pair_t trig1;
  trig_pair_t trig2;
  vec_t       in_vec;
  vec_t       vec1;
  vec_t       vec2;
  vec_t       vec3;
  logic       st_ready;
  logic       valid1;
  logic       ready1;
  logic       valid2;
  logic       ready2;

  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= 1'b0;
    end else if (cfg_fire && cfg_index == REG_ORDER) begin
      order <= cfg_data[0];
    end
  end

  evr_trig_seq u_trig (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_fire && cfg_index != REG_ORDER),
    .sel    (cfg_index),
    .angle  (cfg_data),
    .busy   (busy),
    .trig_x (trig_x),
    .trig_y (trig_y),
    .trig_z (trig_z)
  );

  // Order 0 turns about Y first, order 1 about X first; Z always last.
  always_comb begin
    if (order) begin
      plane1 = PL_YZ; trig1 = trig_x;
      plane2 = PL_XZ; trig2 = trig_y;
    end else begin
      plane1 = PL_XZ; trig1 = trig_y;
      plane2 = PL_YZ; trig2 = trig_x;
    end
  end

  assign in_vec   = s_tdata[3*COORD_WIDTH-1:0];
  assign s_tready = st_ready && !busy;

  evr_rot_stage u_rot1 (
    .clk       (clk),
    .rst       (rst),
    .plane     (plane1),
    .trig      (trig1),
    .in_valid  (s_tvalid && !busy),
    .in_ready  (st_ready),
    .in_vec    (in_vec),
    .out_valid (valid1),
    .out_ready (ready1),
    .out_vec   (vec1)
  );

  evr_rot_stage u_rot2 (
    .clk       (clk),
    .rst       (rst),
    .plane     (plane2),
    .trig      (trig2),
    .in_valid  (valid1),
    .in_ready  (ready1),
    .in_vec    (vec1),
    .out_valid (valid2),
    .out_ready (ready2),
    .out_vec   (vec2)
  );

  evr_rot_stage u_rot3 (
    .clk       (clk),
    .rst       (rst),
    .plane     (PL_XY),
    .trig      (trig_z),
    .in_valid  (valid2),
    .in_ready  (ready2),
    .in_vec    (vec2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_vec   (vec3)
  );

  assign m_tdata = TDATA_W'(vec3);

  a_refresh_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_fire && cfg_index != REG_ORDER |=> !s_tready && !cfg_ready)
    else $error("angle write did not block the input");

endmodule

### tb/euler_vertex_rotation_top_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// euler_vertex_rotation_top_tb
// Self-checking testbench for the Euler vertex rotation block. A behavioral
// model of the trig cache and the three planar rotations predicts every
// output vertex, which is compared field by field with the output stream
// while either stream side may stall at random.
//------------------------------------------------------------------------------
module euler_vertex_rotation_top_tb;
  import evr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata;   // in_x, in_y, in_z
  logic                 m_tvalid;
  logic                 m_tready;
  logic [TDATA_W-1:0]   m_tdata;   // out_x, out_y, out_z
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_WIDTH-1:0] cfg_index;
  logic [ANG_WIDTH-1:0] cfg_data;

  euler_vertex_rotation_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state: angle registers, order, and the sine/cosine cache.
  logic [ANG_WIDTH-1:0] angle_reg [3];
  logic                 order_reg;
  longint               sin_cache [3];
  longint               cos_cache [3];

  vec_t   rotated_q [$];
  int     error_count;
  longint cycle_count;
  bit     sink_busy;     // when clear, the output side never stalls
  bit     source_busy;   // when clear, the input side never idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** euler_vertex_rotation_top: FAILED **");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint q30_to_trig(longint unsigned v);
    return longint'((v + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT);
  endfunction

  task automatic angle_sincos(input logic [ANG_WIDTH-1:0] raw,
                              output longint s, output longint c);
    longint a, r, q, f, g, sf, cf, tmp;
    longint unsigned x, x2, t, sv, cv, one;
    one = 64'd1 << 30;
    a = longint'($signed(raw));
    r = a % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    q = r / QUARTER_TURN;
    f = r % QUARTER_TURN;
    g = (f <= EIGHTH_TURN) ? f : QUARTER_TURN - f;
    x = ($unsigned(g) * 64'd3373259426 + 64'd23040) / 64'd46080;
    x2 = mul_q30(x, x);
    t = one - x2 / 72;
    t = one - mul_q30(x2, t) / 42;
    t = one - mul_q30(x2, t) / 20;
    t = one - mul_q30(x2, t) / 6;
    sv = mul_q30(x, t);
    t = one - x2 / 90;
    t = one - mul_q30(x2, t) / 56;
    t = one - mul_q30(x2, t) / 30;
    t = one - mul_q30(x2, t) / 12;
    cv = one - mul_q30(x2, t) / 2;
    sf = q30_to_trig(sv);
    cf = q30_to_trig(cv);
    if (f > EIGHTH_TURN) begin
      tmp = sf; sf = cf; cf = tmp;
    end
    case (q)
      0: begin s = sf;  c = cf;  end
      1: begin s = cf;  c = -sf; end
      2: begin s = -sf; c = -cf; end
      default: begin s = -cf; c = sf; end
    endcase
  endtask

  // round((a*c + b*s) / 2^F), clamped to the coordinate range
  function automatic longint mac_round(longint a, longint c, longint b, longint s);
    longint v;
    v = (a * c + b * s + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic turn_plane(inout longint u, inout longint v, input longint s,
                            input longint c);
    longint nu, nv;
    nu = mac_round(u, c, v, -s);
    nv = mac_round(u, s, v, c);
    u = nu;
    v = nv;
  endtask

  task automatic rotate_vertex(input vec_t vin, output vec_t vout);
    longint x, y, z;
    x = longint'(vin.x);
    y = longint'(vin.y);
    z = longint'(vin.z);
    if ((angle_reg[0] | angle_reg[1] | angle_reg[2]) != '0) begin
      if (order_reg == 1'b0) begin
        turn_plane(x, z, sin_cache[1], cos_cache[1]);
        turn_plane(y, z, sin_cache[0], cos_cache[0]);
      end else begin
        turn_plane(y, z, sin_cache[0], cos_cache[0]);
        turn_plane(x, z, sin_cache[1], cos_cache[1]);
      end
      turn_plane(x, y, sin_cache[2], cos_cache[2]);
    end
    vout.x = coord_t'(x);
    vout.y = coord_t'(y);
    vout.z = coord_t'(z);
  endtask

  // Output checker: each transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    vec_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = vec_t'(m_tdata[3*COORD_WIDTH-1:0]);
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected output vertex x=%0d y=%0d z=%0d",
                 $time, got.x, got.y, got.z);
        error_count++;
      end else begin
        want = rotated_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
          error_count++;
        end
        if (got.y !== want.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
          error_count++;
        end
        if (got.z !== want.z) begin
          $display("%0t: out_z expected %0d actual %0d", $time, want.z, got.z);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || !sink_busy) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) < 70) || (gap_len() == 0);
    end
  end

  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    vec_t v, r;
    int gap;
    v.x = x; v.y = y; v.z = z;
    gap = source_busy ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(v);
    do @(posedge clk); while (!s_tready);
    rotate_vertex(v, r);
    rotated_q = {rotated_q, r};
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx,
                           input logic [ANG_WIDTH-1:0] data);
    int i;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ORDER) begin
      order_reg = data[0];
    end else begin
      angle_reg[idx] = data;
      for (i = 0; i < 3; i++) angle_sincos(angle_reg[i], sin_cache[i], cos_cache[i]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return coord_t'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
    endcase
  endfunction

  function automatic logic [ANG_WIDTH-1:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ANG_WIDTH'($urandom);
      2: return ANG_WIDTH'(QUARTER_TURN * $signed($urandom_range(0, 8) - 4));
      default: return ANG_WIDTH'($signed($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
    endcase
  endfunction

  // With all angles zero the vertex must pass through untouched.
  task automatic test_bypass();
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
    send_vertex(32'sh80000000, 32'sh7FFFFFFF, -32'sh1);
    send_vertex(32'sh00010000, 32'sh00020000, 32'sh00030000);
  endtask

  // Quarter turns, full turns and register extremes with extreme vertices.
  task automatic test_angle_extremes();
    write_reg(REG_ORDER, 18'd0);
    write_reg(REG_ANGLE_Y, ANG_WIDTH'(QUARTER_TURN));
    send_vertex(32'sh00010000, 32'sh00020000, 32'sh00030000);
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    write_reg(REG_ANGLE_X, ANG_WIDTH'(FULL_TURN));
    write_reg(REG_ANGLE_Y, ANG_WIDTH'(-FULL_TURN));
    write_reg(REG_ANGLE_Z, ANG_WIDTH'(EIGHTH_TURN));
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    write_reg(REG_ANGLE_X, 18'h1FFFF);
    write_reg(REG_ANGLE_Y, 18'h20000);
    write_reg(REG_ANGLE_Z, ANG_WIDTH'(-EIGHTH_TURN + 1));
    send_vertex(32'sh12345678, -32'sh0ABCDEF0, 32'sh00000001);
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
  endtask

  // The same angles are applied under both rotation orders.
  task automatic test_orders();
    write_reg(REG_ANGLE_X, ANG_WIDTH'(30 * 256));
    write_reg(REG_ANGLE_Y, ANG_WIDTH'(45 * 256));
    write_reg(REG_ANGLE_Z, ANG_WIDTH'(-60 * 256));
    send_vertex(32'sh00010000, 32'sh00010000, 32'sh00010000);
    write_reg(REG_ORDER, 18'h3FFFF);
    send_vertex(32'sh00010000, 32'sh00010000, 32'sh00010000);
    send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    write_reg(REG_ORDER, 18'h3FFFE);
  endtask

  task automatic test_random_stream();
    int phase, n, i;
    for (phase = 0; phase < 10; phase++) begin
      if (phase > 0) begin
        for (i = 0; i < 3; i++) begin
          if ($urandom_range(0, 2) != 0) write_reg(IDX_WIDTH'(i), rand_angle());
        end
        write_reg(REG_ORDER, ANG_WIDTH'($urandom));
      end
      source_busy = (phase % 3) != 1;
      sink_busy   = (phase % 4) != 2;
      n = 120;
      for (i = 0; i < n; i++) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord());
        if (phase == 5 && i == n / 2) wait_drained();
      end
    end
    source_busy = 1'b1;
    sink_busy   = 1'b1;
  endtask

  initial begin
    int i;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    sink_busy = 1'b1;
    source_busy = 1'b1;
    order_reg = 1'b0;
    for (i = 0; i < 3; i++) begin
      angle_reg[i] = '0;
      sin_cache[i] = 0;
      cos_cache[i] = longint'(1) << TRIG_FRAC;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_bypass();
    test_angle_extremes();
    test_orders();
    test_random_stream();

    wait_drained();
    if (error_count == 0) begin
      $display("** euler_vertex_rotation_top: PASSED **");
    end else begin
      $display("** euler_vertex_rotation_top: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/evr_pkg.sv
hw/rtl/evr_div.sv
hw/rtl/evr_trig_seq.sv
hw/rtl/evr_rot_stage.sv
hw/rtl/euler_vertex_rotation_top.sv
tb/euler_vertex_rotation_top_tb.sv
